>>> hw/rtl/bls_pkg.sv
package bls_pkg;

   // fixed field widths
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 7;

   // defaults
   localparam int DEF_MAX_DEPTH = 64;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH      = 2'd0;
   localparam logic [OP_W-1:0] OP_POP       = 2'd1;
   localparam logic [OP_W-1:0] OP_DUMP_DOWN = 2'd2;
   localparam logic [OP_W-1:0] OP_DUMP_UP   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic                push_write;
      logic                pop_start;
      logic                dump_start;
      logic                dump_up;
      logic                next_read;
      logic                out_load;
      logic                out_entry;
      logic [STATUS_W-1:0] out_status;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic last_entry;
   } stat_type;

endpackage

>>> hw/rtl/bls_datapath.sv
module bls_datapath
   import bls_pkg::*;
#(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [DATA_W-1:0]   push_value,
   input  logic                csr_we,
   input  logic [CAP_W-1:0]    csr_wdata,
   output logic [DATA_W-1:0]   out_data,
   output logic [STATUS_W-1:0] out_status,
   output logic                out_last
);

   localparam int AW = $clog2(MAX_DEPTH);
   localparam int CW = $clog2(MAX_DEPTH + 1);

   logic [DATA_W-1:0] mem [MAX_DEPTH];

   logic [CW-1:0]       count_ff, count_in;
   logic [CAP_W-1:0]    cap_ff;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       left_ff, left_in;
   logic                up_ff, up_in;
   logic [DATA_W-1:0]   rdata_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                last_ff;

   logic [AW-1:0] top_addr;
   logic [AW-1:0] wr_addr;
   logic          rd_en;

   assign top_addr = AW'(count_ff - CW'(1));
   assign wr_addr  = AW'(count_ff);

   // full when count reaches capacity, capacity saturating at the depth
   assign stat.full       = (CAP_W'(count_ff) >= cap_ff) || (count_ff == CW'(MAX_DEPTH));
   assign stat.empty      = (count_ff == '0);
   assign stat.last_entry = (left_ff == CW'(1));

   // read pointer, remaining entries and count
   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      left_in  = left_ff;
      up_in    = up_ff;
      rd_en    = 1'b0;
      if (cmd.push_write) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_start) begin
         count_in = count_ff - CW'(1);
         ptr_in   = top_addr;
         left_in  = CW'(1);
         rd_en    = 1'b1;
      end else if (cmd.dump_start) begin
         up_in   = cmd.dump_up;
         ptr_in  = cmd.dump_up ? '0 : top_addr;
         left_in = count_ff;
         rd_en   = 1'b1;
      end else if (cmd.next_read) begin
         ptr_in  = up_ff ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
         left_in = left_ff - CW'(1);
         rd_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      left_ff <= left_in;
      up_ff   <= up_in;
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.push_write) begin
         mem[wr_addr] <= push_value;
      end
      if (rd_en) begin
         rdata_ff <= mem[ptr_in];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_entry) begin
            data_ff   <= rdata_ff;
            status_ff <= STATUS_OK;
            last_ff   <= stat.last_entry;
         end else begin
            data_ff   <= '0;
            status_ff <= cmd.out_status;
            last_ff   <= 1'b1;
         end
      end
   end

   assign out_data   = data_ff;
   assign out_status = status_ff;
   assign out_last   = last_ff;

endmodule

>>> hw/rtl/bls_ctrl.sv
module bls_ctrl
   import bls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  stat_type        stat,
   output cmd_type         cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;
   logic valid_ff, valid_in;
   logic slot_free;

   assign slot_free = !valid_ff || rsp_ready;
   assign req_ready = !reset && (state_ff == ST_IDLE) && slot_free;
   assign rsp_valid = valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (req_op) inside
                  OP_PUSH: begin
                     cmd.out_load = 1'b1;
                     if (stat.full) begin
                        cmd.out_status = STATUS_FULL;
                     end else begin
                        cmd.out_status = STATUS_OK;
                        cmd.push_write = 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (stat.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STATUS_EMPTY;
                     end else begin
                        cmd.pop_start = 1'b1;
                        state_in      = ST_EMIT;
                     end
                  end
                  OP_DUMP_DOWN, OP_DUMP_UP: begin
                     if (stat.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STATUS_EMPTY;
                     end else begin
                        cmd.dump_start = 1'b1;
                        cmd.dump_up    = (req_op == OP_DUMP_UP);
                        state_in       = ST_EMIT;
                     end
                  end
                  default: begin
                     cmd = '0;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // when the result slot is free, hand out the entry just read and fetch the next one unless it was the last
            if (slot_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_entry = 1'b1;
               if (stat.last_entry) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_read = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> hw/rtl/bounded_lifo_stack_core.sv
// channel  | direction | ports                        | contents
// req      | in        | req_tvalid/tready/tdata/tuser | item: tdata push_value, tuser op
// rsp      | out       | rsp_tvalid/tready/tdata/tuser/tlast | item: data_value, status, last
// csr      | in        | csr_we/csr_wdata             | capacity register
//
// push and error items reach the result register in the cycle after they are accepted
// pop: registered memory read, then result register; dump: the same for every stored entry
// entry memory's single read port fetches ahead as entries go out; input held off meanwhile
// reset clears the entry count (stack empty), sets capacity to 64, holds req_tready low
// a stalled result holds the listing and holds off the next item until it is taken
module bounded_lifo_stack_core
   import bls_pkg::*;
#(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [31:0] push_value
   input  logic [OP_W-1:0]     req_tuser,   // [1:0] op
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // [31:0] data_value
   output logic [STATUS_W-1:0] rsp_tuser,   // [1:0] status
   output logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [CAP_W-1:0]    csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   bls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bls_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .push_value (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .out_data   (rsp_tdata),
      .out_status (rsp_tuser),
      .out_last   (rsp_tlast)
   );

endmodule
